/* design/sfd_pkg.sv */
// shared types and constants of the sound fifo dma refill block
`default_nettype none

package sfd_pkg;

  // opcodes of an input item
  localparam logic [1:0] OPC_WRITE = 2'd0;
  localparam logic [1:0] OPC_TIMER = 2'd1;
  localparam logic [1:0] OPC_VSYNC = 2'd2;

  // targets of a result item
  localparam logic [1:0] TGT_FIFO_A = 2'd0;
  localparam logic [1:0] TGT_FIFO_B = 2'd1;
  localparam logic [1:0] TGT_TIMER  = 2'd2;

  // register index, taken from paddr[2]
  localparam logic REG_RING_SIZE  = 1'b0;
  localparam logic REG_DMA_PERIOD = 1'b1;

  localparam int RING_SIZE_W    = 13;
  localparam int DMA_PERIOD_W   = 8;
  localparam int RING_INDEX_W   = 12;
  localparam int FIFO_PTR_W     = 3;
  localparam int BYTES_PER_WORD = 4;
  localparam int REFILL_BYTES   = 16;
  localparam int BYTE_CNT_W     = 5;

  localparam logic [RING_SIZE_W-1:0]  RING_SIZE_RST  = 13'd4096;
  localparam logic [DMA_PERIOD_W-1:0] DMA_PERIOD_RST = 8'd7;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_TIMER,
    CMD_VSYNC
  } sfd_cmd_e;

  typedef struct packed {
    sfd_cmd_e                op;
    logic                    channel;
    logic [RING_INDEX_W-1:0] index;
    logic [7:0]              data;
  } sfd_cmd_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } sfd_stat_t;

endpackage

`default_nettype wire

/* design/sfd_front.sv */
// front end: accepts and classifies items, holds them in a two-entry queue
`default_nettype none

module sfd_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic [1:0]                   opcode_i,
  input  logic                         channel_i,
  input  logic [11:0]                  ring_index_i,
  input  logic [7:0]                   ring_byte_i,
  output logic                         cmd_valid_o,
  output sfd_pkg::sfd_cmd_t            cmd_o,
  input  sfd_pkg::sfd_stat_t           stat_i
);
  import sfd_pkg::*;

  sfd_cmd_t   queue_q [2];
  logic [1:0] count_q;
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic       full;
  logic       accept;
  logic       push;
  logic       known_op;
  sfd_cmd_t   cmd_new;

  always_comb begin
    known_op        = 1'b1;
    cmd_new.op      = CMD_WRITE;
    cmd_new.channel = channel_i;
    cmd_new.index   = ring_index_i;
    cmd_new.data    = ring_byte_i;
    unique case (opcode_i)
      OPC_WRITE: cmd_new.op = CMD_WRITE;
      OPC_TIMER: cmd_new.op = CMD_TIMER;
      OPC_VSYNC: cmd_new.op = CMD_VSYNC;
      default:   known_op   = 1'b0;   // unused opcode is dropped
    endcase
  end

  assign full        = (count_q == 2'd2);
  assign busy_o      = full | stat_i.clearing;
  assign accept      = start_i & ~busy_o;
  assign push        = accept & known_op;
  assign cmd_valid_o = (count_q != 2'd0);
  assign cmd_o       = queue_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (stat_i.pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      unique case ({push, stat_i.pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

`default_nettype wire

/* design/sfd_back.sv */
// back end: ring stores, fifo bookkeeping, burst reader and result emission
`default_nettype none

module sfd_back #(
  parameter int RING_BYTES = 4096
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cmd_valid_i,
  input  sfd_pkg::sfd_cmd_t        cmd_i,
  output sfd_pkg::sfd_stat_t       stat_o,
  input  logic [12:0]              ring_size_i,
  input  logic [7:0]               dma_period_i,
  output logic                     result_valid_o,
  output logic [1:0]               event_target_o,
  output logic [31:0]              event_value_o,
  output logic                     last_event_o
);
  import sfd_pkg::*;

  localparam int SIZE_MAX_W = (1 << RING_SIZE_W) - 1;
  localparam int AW      = $clog2(RING_BYTES);
  localparam int EFF_MAX = (RING_BYTES < SIZE_MAX_W) ? RING_BYTES : SIZE_MAX_W;
  localparam int CW      = $clog2(EFF_MAX);
  localparam int SW      = $clog2(EFF_MAX + 1);
  localparam int LW      = ($clog2(RING_BYTES + 1) > RING_SIZE_W) ?
                           $clog2(RING_BYTES + 1) : RING_SIZE_W;
  localparam int XW      = (AW + 1 > RING_INDEX_W) ? AW + 1 : RING_INDEX_W;
  localparam int BW      = $clog2(CW);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_EVENT
  } state_e;

  state_e st_q;

  // ring stores
  logic [7:0]    ring_a_mem [RING_BYTES];
  logic [7:0]    ring_b_mem [RING_BYTES];
  logic [7:0]    rdata_a_q;
  logic [7:0]    rdata_b_q;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [7:0]    wr_byte;
  logic          we_a;
  logic          we_b;
  logic [AW-1:0] clr_q;

  // channel state
  logic [FIFO_PTR_W-1:0]   rd_a_q, wr_a_q, rd_b_q, wr_b_q;
  logic [2:0]              left_a_q, left_b_q;
  logic [CW-1:0]           cur_a_q, cur_b_q;
  logic [DMA_PERIOD_W-1:0] epoch_q;

  // burst sequencing
  logic                  ch_q;
  logic                  need_b_q;
  logic                  ev_q;
  logic [BYTE_CNT_W-1:0] k_q;
  logic [BW-1:0]         bit_q;
  logic [SW-1:0]         rem_q;
  logic [CW-1:0]         r_q;
  logic [31:0]           word_q;

  // result register
  logic        valid_q;
  logic        valid_d;
  logic [1:0]  target_q;
  logic [31:0] value_q;
  logic        last_q;

  logic                  clearing;
  logic                  pop;
  logic [XW-1:0]         widx;
  logic                  w_in_range;
  logic [LW-1:0]         rs_ext;
  logic [LW-1:0]         eff_l;
  logic [SW-1:0]         eff;
  logic [FIFO_PTR_W-1:0] queued_a, queued_b;
  logic                  need_a_now, need_b_now;
  logic                  had_a, had_b;
  logic                  cons_a, cons_b;
  logic [2:0]            left_a_n, left_b_n;
  logic [FIFO_PTR_W-1:0] rd_a_n, rd_b_n;
  logic                  lch;
  logic [CW-1:0]         l_cur;
  logic                  l_direct;
  logic [CW-1:0]         mod_src;
  logic [SW:0]           rem_t;
  logic [SW:0]           rem_n;
  logic [SW-1:0]         r_inc;
  logic [CW-1:0]         r_next;
  logic [7:0]            byte_in;
  logic [31:0]           word_n;

  assign clearing = (st_q == ST_CLEAR);
  assign pop      = (st_q == ST_IDLE) && cmd_valid_i;
  assign stat_o.pop      = pop;
  assign stat_o.clearing = clearing;

  // write port: clearing sweep or a ring write
  always_comb begin
    widx       = XW'(cmd_i.index);
    w_in_range = widx < XW'(RING_BYTES);
    we_a       = clearing || (pop && cmd_i.op == CMD_WRITE && w_in_range && !cmd_i.channel);
    we_b       = clearing || (pop && cmd_i.op == CMD_WRITE && w_in_range && cmd_i.channel);
    wr_addr    = clearing ? clr_q : widx[AW-1:0];
    wr_byte    = clearing ? 8'd0 : cmd_i.data;
    rd_addr    = AW'(r_q);
  end

  always_ff @(posedge clk_i) begin
    if (we_a) begin
      ring_a_mem[wr_addr] <= wr_byte;
    end
    if (we_b) begin
      ring_b_mem[wr_addr] <= wr_byte;
    end
    rdata_a_q <= ring_a_mem[rd_addr];
    rdata_b_q <= ring_b_mem[rd_addr];
  end

  always_comb begin
    // ring size saturates at the store depth
    rs_ext = LW'(ring_size_i);
    eff_l  = (rs_ext > LW'(RING_BYTES)) ? LW'(RING_BYTES) : rs_ext;
    eff    = eff_l[SW-1:0];

    queued_a   = wr_a_q - rd_a_q;
    queued_b   = wr_b_q - rd_b_q;
    need_a_now = !queued_a[2] && (eff != '0);
    need_b_now = !queued_b[2] && (eff != '0);
    had_a      = (wr_a_q != rd_a_q);
    had_b      = (wr_b_q != rd_b_q);

    // consumption of one byte per channel
    cons_a   = (left_a_q != 3'd0) || had_a;
    cons_b   = (left_b_q != 3'd0) || had_b;
    left_a_n = (left_a_q == 3'd0) ? (had_a ? 3'(BYTES_PER_WORD - 1) : 3'd0)
                                  : left_a_q - 3'd1;
    left_b_n = (left_b_q == 3'd0) ? (had_b ? 3'(BYTES_PER_WORD - 1) : 3'd0)
                                  : left_b_q - 3'd1;
    rd_a_n   = (left_a_q == 3'd0 && had_a) ? rd_a_q + 1'b1 : rd_a_q;
    rd_b_n   = (left_b_q == 3'd0 && had_b) ? rd_b_q + 1'b1 : rd_b_q;

    // channel of the next burst and whether its cursor is already reduced
    lch      = (st_q == ST_IDLE) ? !need_a_now : 1'b1;
    l_cur    = lch ? cur_b_q : cur_a_q;
    l_direct = SW'(l_cur) < eff;

    // one bit of the restoring remainder per cycle
    mod_src = ch_q ? cur_b_q : cur_a_q;
    rem_t   = {rem_q, mod_src[bit_q]};
    rem_n   = (rem_t >= {1'b0, eff}) ? rem_t - {1'b0, eff} : rem_t;

    // read cursor steps by one and wraps at the ring size
    r_inc  = SW'(r_q) + SW'(1);
    r_next = (r_inc == eff) ? '0 : r_inc[CW-1:0];

    byte_in = ch_q ? rdata_b_q : rdata_a_q;
    word_n  = {byte_in, word_q[31:8]};

    // a result leaves on a timer item with no burst that consumes a byte, on every fourth
    // burst byte and from the event state
    unique case (st_q)
      ST_IDLE:  valid_d = cmd_valid_i && (cmd_i.op == CMD_TIMER) &&
                          !(need_a_now || need_b_now) && (cons_a || cons_b);
      ST_READ:  valid_d = (k_q != '0) && (k_q[1:0] == 2'b00);
      ST_EVENT: valid_d = 1'b1;
      default:  valid_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_CLEAR;
      clr_q    <= '0;
      rd_a_q   <= '0;
      wr_a_q   <= '0;
      rd_b_q   <= '0;
      wr_b_q   <= '0;
      left_a_q <= '0;
      left_b_q <= '0;
      cur_a_q  <= '0;
      cur_b_q  <= '0;
      epoch_q  <= '0;
      ch_q     <= 1'b0;
      need_b_q <= 1'b0;
      ev_q     <= 1'b0;
      k_q      <= '0;
      bit_q    <= '0;
      rem_q    <= '0;
      r_q      <= '0;
      word_q   <= '0;
      valid_q  <= 1'b0;
      target_q <= '0;
      value_q  <= '0;
      last_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      unique case (st_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == AW'(RING_BYTES - 1)) begin
            st_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (cmd_valid_i) begin
            unique case (cmd_i.op)
              CMD_WRITE: begin
              end
              CMD_VSYNC: begin
                if (epoch_q > 8'd1) begin
                  epoch_q <= epoch_q - 8'd1;
                end else begin
                  epoch_q <= dma_period_i;
                  cur_a_q <= '0;
                  cur_b_q <= '0;
                end
              end
              CMD_TIMER: begin
                rd_a_q   <= rd_a_n;
                rd_b_q   <= rd_b_n;
                left_a_q <= left_a_n;
                left_b_q <= left_b_n;
                ev_q     <= cons_a | cons_b;
                need_b_q <= need_b_now;
                if (need_a_now || need_b_now) begin
                  ch_q  <= lch;
                  k_q   <= '0;
                  rem_q <= '0;
                  bit_q <= BW'(CW - 1);
                  r_q   <= l_cur;
                  st_q  <= l_direct ? ST_READ : ST_MOD;
                end else if (cons_a || cons_b) begin
                  target_q <= TGT_TIMER;
                  value_q  <= '0;
                  last_q   <= 1'b1;
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_MOD: begin
          rem_q <= rem_n[SW-1:0];
          bit_q <= bit_q - 1'b1;
          if (bit_q == '0) begin
            r_q  <= rem_n[CW-1:0];
            k_q  <= '0;
            st_q <= ST_READ;
          end
        end
        ST_READ: begin
          k_q <= (k_q == BYTE_CNT_W'(REFILL_BYTES)) ? '0 : k_q + 1'b1;
          if (k_q < BYTE_CNT_W'(REFILL_BYTES)) begin
            r_q <= r_next;
          end
          if (k_q != '0) begin
            word_q <= word_n;
            if (k_q[1:0] == 2'b00) begin
              target_q <= ch_q ? TGT_FIFO_B : TGT_FIFO_A;
              value_q  <= word_n;
              last_q   <= (k_q == BYTE_CNT_W'(REFILL_BYTES)) && !ev_q &&
                          (ch_q || !need_b_q);
              if (ch_q) begin
                wr_b_q <= wr_b_q + 1'b1;
              end else begin
                wr_a_q <= wr_a_q + 1'b1;
              end
            end
          end
          if (k_q == BYTE_CNT_W'(REFILL_BYTES)) begin
            if (ch_q) begin
              cur_b_q <= r_q;
            end else begin
              cur_a_q <= r_q;
            end
            if (!ch_q && need_b_q) begin
              ch_q  <= lch;
              rem_q <= '0;
              bit_q <= BW'(CW - 1);
              r_q   <= l_cur;
              st_q  <= l_direct ? ST_READ : ST_MOD;
            end else if (ev_q) begin
              st_q <= ST_EVENT;
            end else begin
              st_q <= ST_IDLE;
            end
          end
        end
        ST_EVENT: begin
          target_q <= TGT_TIMER;
          value_q  <= '0;
          last_q   <= 1'b1;
          st_q     <= ST_IDLE;
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign result_valid_o = valid_q;
  assign event_target_o = target_q;
  assign event_value_o  = value_q;
  assign last_event_o   = last_q;

endmodule

`default_nettype wire

/* design/sound_fifo_dma_refill_model.sv */
// top level of the sound fifo dma refill block: config registers, front and back
//
//   channel   | handshake                       | payload
//   ----------+---------------------------------+---------------------------------------
//   item in   | start, busy (taken: start&!busy)| opcode_i channel_i ring_index_i
//             |                                 | ring_byte_i
//   result    | result_valid_o, one cycle       | event_target_o event_value_o
//             |                                 | last_event_o
//   config    | psel penable pwrite, pready=1   | paddr[2] selects register, pwdata/prdata
//
// an item is registered in the queue before the back end takes it
// ring writes and vsync ticks are handled in the back end's idle state; a timer overflow
// runs a refill burst per channel in need (one ring byte read per cycle on the store read
// port), preceded by a bit-serial remainder over the cursor bits (12 at the default depth)
// when a cursor sits at or past a lowered ring size, and followed by the event state for
// the timer result when a burst ran and a byte was consumed
// after reset the two ring stores are swept to zero, one entry a cycle over all RING_BYTES
// entries; busy stays high during the sweep, config writes are still taken
// busy also rises when the two-entry item queue is full
// results cannot be held off: each shows on the result ports for exactly one cycle
`default_nettype none

module sound_fifo_dma_refill_model #(
  parameter int RING_BYTES = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // item in
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode_i,
  input  logic        channel_i,
  input  logic [11:0] ring_index_i,
  input  logic [7:0]  ring_byte_i,
  // results
  output logic        result_valid_o,
  output logic [1:0]  event_target_o,
  output logic [31:0] event_value_o,
  output logic        last_event_o,
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sfd_pkg::*;

  logic [RING_SIZE_W-1:0]  ring_size_q;
  logic [DMA_PERIOD_W-1:0] dma_period_q;
  logic                    cfg_we;
  logic                    cmd_valid;
  sfd_cmd_t                cmd;
  sfd_stat_t               stat;

  // register file, word-aligned decode on paddr[2]
  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_size_q  <= RING_SIZE_RST;
      dma_period_q <= DMA_PERIOD_RST;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_RING_SIZE:  ring_size_q  <= pwdata[RING_SIZE_W-1:0];
        REG_DMA_PERIOD: dma_period_q <= pwdata[DMA_PERIOD_W-1:0];
        default:        ring_size_q  <= ring_size_q;
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_DMA_PERIOD) ? 32'(dma_period_q) : 32'(ring_size_q);

  // front: classify and queue items
  sfd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .busy_o       (busy),
    .opcode_i     (opcode_i),
    .channel_i    (channel_i),
    .ring_index_i (ring_index_i),
    .ring_byte_i  (ring_byte_i),
    .cmd_valid_o  (cmd_valid),
    .cmd_o        (cmd),
    .stat_i       (stat)
  );

  // back: ring stores, bursts and results
  sfd_back #(
    .RING_BYTES (RING_BYTES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_valid_i    (cmd_valid),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .ring_size_i    (ring_size_q),
    .dma_period_i   (dma_period_q),
    .result_valid_o (result_valid_o),
    .event_target_o (event_target_o),
    .event_value_o  (event_value_o),
    .last_event_o   (last_event_o)
  );

endmodule

`default_nettype wire

/* design/sfd_checker.sv */
// port-level checks of the sound fifo dma refill block and their bind
`default_nettype none

module sfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        busy,
  input logic        result_valid_o,
  input logic [1:0]  event_target_o,
  input logic [31:0] event_value_o,
  input logic        last_event_o,
  input logic        pready
);
  import sfd_pkg::*;

  // the store sweep keeps the block busy through reset and the cycle after
  a_busy_in_reset: assert property (@(posedge clk_i) !rst_ni |=> busy)
    else $error("busy low during reset");

  a_pready_high: assert property (@(posedge clk_i) pready)
    else $error("pready low");

  // a timer result carries zero and closes its item
  a_timer_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && event_target_o == TGT_TIMER) |-> (event_value_o == 32'd0 && last_event_o))
    else $error("malformed timer result");

  // fifo words never come back to back
  a_word_spacing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && event_target_o != TGT_TIMER) |=>
      !(result_valid_o && event_target_o != TGT_TIMER))
    else $error("fifo words back to back");

endmodule

bind sound_fifo_dma_refill_model sfd_checker u_sfd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .event_target_o (event_target_o),
  .event_value_o  (event_value_o),
  .last_event_o   (last_event_o),
  .pready         (pready)
);

`default_nettype wire
